/* hw/rtl/sas_pkg.sv */
// shared types and constants of the strategy automaton stepper
`default_nettype none

package sas_pkg;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int STATE_W    = 8;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 4;
  localparam int SENS_W     = 16;
  localparam int SYS_W      = 16;
  localparam int REG_W      = 8;
  localparam int NPROP_W    = 5;
  localparam int NSTATES_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // limits that the field widths settle
  localparam int MAX_SENSORS   = 16;
  localparam int MAX_SYS_PROPS = 16;
  localparam int REGION_BITS   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ENTRY = 2'd0,
    CMD_LOAD_SUCC  = 2'd1,
    CMD_STEP       = 2'd2,
    CMD_COMMIT     = 2'd3
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SENSORS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYS_PROPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES    = 2'd2;

  // one word of the state table
  typedef struct packed {
    logic [SENS_W-1:0] sensor;
    logic [SYS_W-1:0]  sys;
    logic [REG_W-1:0]  region;
    logic [CNT_W-1:0]  count;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic ld_entry;
    logic ld_succ;
    logic commit;
    logic step_start;
    logic ent_rd;
    logic ent_rd_cur;
    logic succ_rd;
    logic k_inc;
    logic n_load;
    logic latch_s;
    logic hit;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero;
    logic last;
    logic s_ok;
    logic match;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/strategy_automaton_stepper_top.sv */
// top level of the strategy automaton stepper
//
// usage:
// - input channel (in_valid_i / in_stall_o) carries one beat per command:
//   load state entry, load successor slot, step with a sensor vector, commit
// - output channel (out_valid_o / out_stall_i) returns exactly one beat per
//   input beat, in order; non-step beats report zeros plus the current state
// - config port: cfg_we_i writes num_sensors, num_sys_props or num_states at
//   index cfg_idx_i; other indexes are ignored; the user must write only while
//   the block is idle, which the block itself does not enforce
// - a load or commit goes straight to the done state; a step first reads the
//   entry count, then per successor (up to 8 by default) reads the successor
//   table, then the state table at the returned address if that id is in range
// - in_stall_o is low whenever the sequencer is idle, even if the previous
//   result beat is still held; a new result then waits in the result register
//   and the sequencer holds in its final state while out_stall_i stays high
// - reset clears the configuration, current and pending state and the output
//   valid; the tables are not cleared and must be loaded before use
`default_nettype none

module strategy_automaton_stepper_top
  import sas_pkg::*;
#(
  parameter int MAX_STATES = 256,
  parameter int MAX_SUCC   = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [CMD_W-1:0]      in_cmd_i,
  input  wire logic [STATE_W-1:0]    in_state_index_i,
  input  wire logic [SLOT_W-1:0]     in_slot_i,
  input  wire logic [STATE_W-1:0]    in_succ_id_i,
  input  wire logic [CNT_W-1:0]      in_succ_count_i,
  input  wire logic [SENS_W-1:0]     in_sensor_bits_i,
  input  wire logic [SYS_W-1:0]      in_sys_bits_i,
  input  wire logic [REG_W-1:0]      in_region_code_i,
  // output channel
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic                  out_found_o,
  output      logic [STATE_W-1:0]    out_next_state_o,
  output      logic [SYS_W-1:0]      out_sys_out_o,
  output      logic [REG_W-1:0]      out_region_o,
  output      logic [STATE_W-1:0]    out_current_state_o
);

  // command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  sas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (cmd_e'(in_cmd_i)),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // tables, automaton registers and the result register
  sas_dp #(
    .MAX_STATES (MAX_STATES),
    .MAX_SUCC   (MAX_SUCC)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .sts_o               (dp_sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_state_index_i    (in_state_index_i),
    .in_slot_i           (in_slot_i),
    .in_succ_id_i        (in_succ_id_i),
    .in_succ_count_i     (in_succ_count_i),
    .in_sensor_bits_i    (in_sensor_bits_i),
    .in_sys_bits_i       (in_sys_bits_i),
    .in_region_code_i    (in_region_code_i),
    .out_found_o         (out_found_o),
    .out_next_state_o    (out_next_state_o),
    .out_sys_out_o       (out_sys_out_o),
    .out_region_o        (out_region_o),
    .out_current_state_o (out_current_state_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/sas_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module sas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/sas_ctrl.sv */
// sequencing state machine of the strategy automaton stepper
`default_nettype none

module sas_ctrl
  import sas_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire cmd_e    in_cmd_i,
  output      logic    in_stall_o,
  input  wire logic    out_stall_i,
  output      logic    out_valid_o,
  input  wire dp_sts_t sts_i,
  output      dp_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CNT  = 3'd1;
  localparam logic [2:0] ST_SUCC = 3'd2;
  localparam logic [2:0] ST_ENT  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_LOAD_ENTRY: begin
              cmd_o.ld_entry = 1'b1;
              state_d        = ST_DONE;
            end
            CMD_LOAD_SUCC: begin
              cmd_o.ld_succ = 1'b1;
              state_d       = ST_DONE;
            end
            CMD_STEP: begin
              cmd_o.step_start = 1'b1;
              cmd_o.ent_rd     = 1'b1;
              cmd_o.ent_rd_cur = 1'b1;
              state_d          = ST_CNT;
            end
            CMD_COMMIT: begin
              cmd_o.commit = 1'b1;
              state_d      = ST_DONE;
            end
          endcase
        end
      end
      ST_CNT: begin
        cmd_o.n_load = 1'b1;
        if (sts_i.n_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.succ_rd = 1'b1;
          state_d       = ST_SUCC;
        end
      end
      ST_SUCC: begin
        cmd_o.latch_s = 1'b1;
        if (sts_i.s_ok) begin
          cmd_o.ent_rd = 1'b1;
          state_d      = ST_ENT;
        end else if (sts_i.last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.k_inc   = 1'b1;
          cmd_o.succ_rd = 1'b1;
        end
      end
      ST_ENT: begin
        if (sts_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = ST_DONE;
        end else if (sts_i.last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.k_inc   = 1'b1;
          cmd_o.succ_rd = 1'b1;
          state_d       = ST_SUCC;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while held");

  a_step_reads_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_cmd_i == CMD_STEP) |=> state_q == ST_CNT)
    else $error("step beat did not start the count read");

  a_hit_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.hit |=> (state_q == ST_DONE))
    else $error("match did not end the search");

endmodule

`default_nettype wire

/* hw/rtl/sas_dp.sv */
// tables, registers and compare logic of the strategy automaton stepper
`default_nettype none

module sas_dp
  import sas_pkg::*;
#(
  parameter int MAX_STATES = 256,
  parameter int MAX_SUCC   = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output      dp_sts_t               sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [STATE_W-1:0]    in_state_index_i,
  input  wire logic [SLOT_W-1:0]     in_slot_i,
  input  wire logic [STATE_W-1:0]    in_succ_id_i,
  input  wire logic [CNT_W-1:0]      in_succ_count_i,
  input  wire logic [SENS_W-1:0]     in_sensor_bits_i,
  input  wire logic [SYS_W-1:0]      in_sys_bits_i,
  input  wire logic [REG_W-1:0]      in_region_code_i,
  output      logic                  out_found_o,
  output      logic [STATE_W-1:0]    out_next_state_o,
  output      logic [SYS_W-1:0]      out_sys_out_o,
  output      logic [REG_W-1:0]      out_region_o,
  output      logic [STATE_W-1:0]    out_current_state_o
);

  localparam int SW         = $clog2(MAX_STATES);
  localparam int KW         = (MAX_SUCC > 1) ? $clog2(MAX_SUCC) : 1;
  localparam int SUCC_DEPTH = MAX_STATES * (2 ** KW);
  localparam int EW         = $bits(entry_t);
  localparam logic [REG_W-1:0] REGION_MASK = REG_W'((1 << REGION_BITS) - 1);

  function automatic logic [15:0] low_mask(input logic [NPROP_W-1:0] n);
    if (n >= NPROP_W'(16)) begin
      return '1;
    end
    return (16'd1 << n) - 16'd1;
  endfunction

  // configuration
  logic [NPROP_W-1:0]   num_sensors_q, num_sys_props_q;
  logic [NSTATES_W-1:0] num_states_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sensors_q   <= '0;
      num_sys_props_q <= '0;
      num_states_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_SENSORS:   num_sensors_q   <= cfg_wdata_i[NPROP_W-1:0];
        CFG_NUM_SYS_PROPS: num_sys_props_q <= cfg_wdata_i[NPROP_W-1:0];
        CFG_NUM_STATES:    num_states_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [NPROP_W-1:0] ns_sat, np_sat;
  logic [SENS_W-1:0]  smask;
  logic [SYS_W-1:0]   pmask;

  assign ns_sat = (num_sensors_q > NPROP_W'(MAX_SENSORS)) ? NPROP_W'(MAX_SENSORS)
                                                          : num_sensors_q;
  assign np_sat = (num_sys_props_q > NPROP_W'(MAX_SYS_PROPS)) ? NPROP_W'(MAX_SYS_PROPS)
                                                              : num_sys_props_q;
  assign smask  = SENS_W'(low_mask(ns_sat));
  assign pmask  = SYS_W'(low_mask(np_sat));

  // load range checks
  logic             idx_ok, slot_ok;
  logic [CNT_W-1:0] cnt_sat;

  assign idx_ok  = 32'(in_state_index_i) < MAX_STATES;
  assign slot_ok = 32'(in_slot_i) < MAX_SUCC;
  assign cnt_sat = (32'(in_succ_count_i) > MAX_SUCC) ? CNT_W'(MAX_SUCC) : in_succ_count_i;

  // automaton registers
  logic [STATE_W-1:0] cur_q, pend_id_q, s_q;
  logic               pend_valid_q;
  logic [CNT_W-1:0]   k_q, n_q, k_sel;
  logic [SENS_W-1:0]  sens_q;

  entry_t             ent_wdata, ent_rdata;
  logic [EW-1:0]      ent_rdata_raw;
  logic [SW-1:0]      ent_raddr;
  logic [STATE_W-1:0] succ_rdata;
  logic [SW+KW-1:0]   succ_waddr, succ_raddr;

  assign ent_wdata = '{sensor: in_sensor_bits_i, sys: in_sys_bits_i,
                       region: in_region_code_i, count: cnt_sat};
  assign ent_raddr = cmd_i.ent_rd_cur ? SW'(cur_q) : SW'(succ_rdata);
  assign ent_rdata = entry_t'(ent_rdata_raw);

  assign k_sel      = cmd_i.k_inc ? (k_q + CNT_W'(1)) : k_q;
  assign succ_waddr = {SW'(in_state_index_i), KW'(in_slot_i)};
  assign succ_raddr = {SW'(cur_q), KW'(k_sel)};

  sas_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_STATES)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_entry & idx_ok),
    .waddr_i (SW'(in_state_index_i)),
    .wdata_i (ent_wdata),
    .re_i    (cmd_i.ent_rd),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata_raw)
  );

  sas_ram #(
    .WIDTH (STATE_W),
    .DEPTH (SUCC_DEPTH)
  ) u_succ_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_succ & idx_ok & slot_ok),
    .waddr_i (succ_waddr),
    .wdata_i (in_succ_id_i),
    .re_i    (cmd_i.succ_rd),
    .raddr_i (succ_raddr),
    .rdata_o (succ_rdata)
  );

  logic commit_ok;
  assign commit_ok = pend_valid_q && ({1'b0, pend_id_q} < num_states_q)
                     && (32'(pend_id_q) < MAX_STATES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '0;
      pend_id_q    <= '0;
      pend_valid_q <= 1'b0;
      k_q          <= '0;
      n_q          <= '0;
    end else begin
      if (cmd_i.commit && commit_ok) begin
        cur_q <= pend_id_q;
      end
      if (cmd_i.step_start) begin
        pend_valid_q <= 1'b0;
        k_q          <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_sel;
      end
      if (cmd_i.hit) begin
        pend_valid_q <= 1'b1;
        pend_id_q    <= s_q;
      end
      if (cmd_i.n_load) begin
        n_q <= ent_rdata.count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_start) begin
      sens_q <= in_sensor_bits_i;
    end
    if (cmd_i.latch_s) begin
      s_q <= succ_rdata;
    end
  end

  assign sts_o.n_zero = (ent_rdata.count == '0);
  assign sts_o.last   = ((k_q + CNT_W'(1)) == n_q);
  assign sts_o.s_ok   = 32'(succ_rdata) < MAX_STATES;
  assign sts_o.match  = (((ent_rdata.sensor ^ sens_q) & smask) == '0);

  // result of the item in flight, zero unless a step matched
  logic               res_found_q;
  logic [STATE_W-1:0] res_next_q;
  logic [SYS_W-1:0]   res_sys_q;
  logic [REG_W-1:0]   res_reg_q;
  logic               any_start;

  assign any_start = cmd_i.ld_entry | cmd_i.ld_succ | cmd_i.commit | cmd_i.step_start;

  always_ff @(posedge clk_i) begin
    if (any_start) begin
      res_found_q <= 1'b0;
      res_next_q  <= '0;
      res_sys_q   <= '0;
      res_reg_q   <= '0;
    end else if (cmd_i.hit) begin
      res_found_q <= 1'b1;
      res_next_q  <= s_q;
      res_sys_q   <= ent_rdata.sys & pmask;
      res_reg_q   <= ent_rdata.region & REGION_MASK;
    end
  end

  // output register
  logic               out_found_q;
  logic [STATE_W-1:0] out_next_q, out_cur_q;
  logic [SYS_W-1:0]   out_sys_q;
  logic [REG_W-1:0]   out_reg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_found_q <= res_found_q;
      out_next_q  <= res_next_q;
      out_sys_q   <= res_sys_q;
      out_reg_q   <= res_reg_q;
      out_cur_q   <= cur_q;
    end
  end

  assign out_found_o         = out_found_q;
  assign out_next_state_o    = out_next_q;
  assign out_sys_out_o       = out_sys_q;
  assign out_region_o        = out_reg_q;
  assign out_current_state_o = out_cur_q;

  a_hit_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hit |=> (pend_valid_q && pend_id_q == $past(s_q)))
    else $error("match did not record the pending state");

  a_cur_moves_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q != $past(cur_q)) |-> ($past(cmd_i.commit) && $past(pend_valid_q)))
    else $error("current state changed without a valid commit");

  a_step_drops_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_start |=> !pend_valid_q)
    else $error("step did not drop the pending state");

endmodule

`default_nettype wire

/* tb/sv/sas_result_checker.sv */
// checker for the stepper: follows both channels and the config port, predicts and compares
`timescale 1ns / 1ps

module sas_result_checker
  import sas_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [CMD_W-1:0]      in_cmd_i,
  input  logic [STATE_W-1:0]    in_state_index_i,
  input  logic [SLOT_W-1:0]     in_slot_i,
  input  logic [STATE_W-1:0]    in_succ_id_i,
  input  logic [CNT_W-1:0]      in_succ_count_i,
  input  logic [SENS_W-1:0]     in_sensor_bits_i,
  input  logic [SYS_W-1:0]      in_sys_bits_i,
  input  logic [REG_W-1:0]      in_region_code_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  out_found_i,
  input  logic [STATE_W-1:0]    out_next_state_i,
  input  logic [SYS_W-1:0]      out_sys_out_i,
  input  logic [REG_W-1:0]      out_region_i,
  input  logic [STATE_W-1:0]    out_current_state_i,
  output int                    mismatches_o,
  output int                    owed_o
);

  localparam int N_STATES = 256;
  localparam int N_SUCC   = 8;

  typedef struct packed {
    logic               found;
    logic [STATE_W-1:0] next_state;
    logic [SYS_W-1:0]   sys_out;
    logic [REG_W-1:0]   region;
    logic [STATE_W-1:0] current_state;
  } step_result_t;

  // automaton tables as the block should hold them
  logic [SENS_W-1:0]    sensor_tab [N_STATES];
  logic [SYS_W-1:0]     sys_tab    [N_STATES];
  logic [REG_W-1:0]     region_tab [N_STATES];
  logic [CNT_W-1:0]     count_tab  [N_STATES];
  logic [STATE_W-1:0]   succ_tab   [N_STATES*N_SUCC];
  logic [NPROP_W-1:0]   n_sensors;
  logic [NPROP_W-1:0]   n_props;
  logic [NSTATES_W-1:0] n_states;
  logic [STATE_W-1:0]   cur_id;
  logic [STATE_W-1:0]   pend_id;
  logic                 pend_ok;
  step_result_t         owed_results [$];

  function automatic logic [15:0] low_ones(int n);
    return (n >= 16) ? 16'hFFFF : 16'((32'd1 << n) - 1);
  endfunction

  function automatic step_result_t advance_automaton(
      cmd_e cmd, logic [STATE_W-1:0] idx, logic [SLOT_W-1:0] slot,
      logic [STATE_W-1:0] sid, logic [CNT_W-1:0] cnt, logic [SENS_W-1:0] sens,
      logic [SYS_W-1:0] sys, logic [REG_W-1:0] region);
    step_result_t r;
    logic [SENS_W-1:0] smask;
    logic [SYS_W-1:0] pmask;
    logic [STATE_W-1:0] s;
    int n;
    r = '0;
    case (cmd)
      CMD_LOAD_ENTRY: begin
        sensor_tab[idx] = sens;
        sys_tab[idx]    = sys;
        region_tab[idx] = region;
        count_tab[idx]  = (cnt > N_SUCC) ? CNT_W'(N_SUCC) : cnt;
      end
      CMD_LOAD_SUCC: succ_tab[{idx, slot}] = sid;
      CMD_STEP: begin
        smask   = low_ones(int'(n_sensors));
        pmask   = low_ones(int'(n_props));
        n       = int'(count_tab[cur_id]);
        pend_ok = 1'b0;
        // first successor in slot order whose compared sensor bits agree
        for (int k = 0; k < n; k++) begin
          s = succ_tab[{cur_id, SLOT_W'(k)}];
          if (!pend_ok && ((sensor_tab[s] ^ sens) & smask) == '0) begin
            pend_ok        = 1'b1;
            pend_id        = s;
            r.found        = 1'b1;
            r.next_state   = s;
            r.sys_out      = sys_tab[s] & pmask;
            r.region       = region_tab[s];
          end
        end
      end
      default: begin
        if (pend_ok && NSTATES_W'(pend_id) < n_states) cur_id = pend_id;
      end
    endcase
    r.current_state = cur_id;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, seen);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin
    step_result_t want;
    if (!rst_ni) begin
      n_sensors    = '0;
      n_props      = '0;
      n_states     = '0;
      cur_id       = '0;
      pend_id      = '0;
      pend_ok      = 1'b0;
      mismatches_o = 0;
      owed_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_SENSORS:   n_sensors = cfg_wdata_i[NPROP_W-1:0];
          CFG_NUM_SYS_PROPS: n_props   = cfg_wdata_i[NPROP_W-1:0];
          CFG_NUM_STATES:    n_states  = cfg_wdata_i;
          default: ;
        endcase
      end
      // the result beat leaving now belongs to an older command, so pop first
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $error("result beat with no command waiting for it");
          mismatches_o++;
        end else begin
          want = owed_results.pop_front();
          check_field("found", 32'(want.found), 32'(out_found_i));
          check_field("next_state", 32'(want.next_state), 32'(out_next_state_i));
          check_field("sys_out", 32'(want.sys_out), 32'(out_sys_out_i));
          check_field("region", 32'(want.region), 32'(out_region_i));
          check_field("current_state", 32'(want.current_state),
                      32'(out_current_state_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        owed_results.insert(owed_results.size(), advance_automaton(cmd_e'(in_cmd_i),
            in_state_index_i, in_slot_i, in_succ_id_i, in_succ_count_i, in_sensor_bits_i,
            in_sys_bits_i, in_region_code_i));
      end
    end
    owed_o = owed_results.size();
  end

endmodule

/* tb/sv/testbench.sv */
// testbench top for the stepper: clock, reset, stimulus, receiver, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
  import sas_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;  // far beyond a step plus any stall run
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off to back up the block
  localparam int PHASE_BEATS     = 35;
  localparam int POOL_SIZE       = 12;
  localparam int N_PHASES        = 8;

  // the block has no register at this index, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // one command beat as the sender drives it
  typedef struct packed {
    cmd_e               cmd;
    logic [STATE_W-1:0] state_index;
    logic [SLOT_W-1:0]  slot;
    logic [STATE_W-1:0] succ_id;
    logic [CNT_W-1:0]   succ_count;
    logic [SENS_W-1:0]  sensor_bits;
    logic [SYS_W-1:0]   sys_bits;
    logic [REG_W-1:0]   region_code;
  } beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd;
  logic [STATE_W-1:0]    in_state_index;
  logic [SLOT_W-1:0]     in_slot;
  logic [STATE_W-1:0]    in_succ_id;
  logic [CNT_W-1:0]      in_succ_count;
  logic [SENS_W-1:0]     in_sensor_bits;
  logic [SYS_W-1:0]      in_sys_bits;
  logic [REG_W-1:0]      in_region_code;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_found;
  logic [STATE_W-1:0]    out_next_state;
  logic [SYS_W-1:0]      out_sys_out;
  logic [REG_W-1:0]      out_region;
  logic [STATE_W-1:0]    out_current_state;
  int                    mismatches;
  int                    owed;

  // knobs shared between the stimulus and the receiver
  int   tx_idle_pct;
  int   rx_stall_pct;
  logic hold_req;

  // what the stimulus knows of the loaded tables, so that a step never walks
  // into an entry or a slot that was never written
  logic               entry_done  [256];
  logic [CNT_W-1:0]   count_sh    [256];
  logic [SENS_W-1:0]  sensor_sh   [256];
  logic [7:0]         slot_done   [256];
  logic [STATE_W-1:0] succ_sh     [256][8];
  logic               may_be_cur  [256];  // states that could be current by now
  logic               may_be_pend [256];  // states that a step could have picked
  int                 cur_list    [$];
  logic [STATE_W-1:0] pool        [$];    // small working set the random part lives in
  logic [NPROP_W-1:0] ns_set;             // num_sensors as last written

  strategy_automaton_stepper_top u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_cmd_i            (in_cmd),
    .in_state_index_i    (in_state_index),
    .in_slot_i           (in_slot),
    .in_succ_id_i        (in_succ_id),
    .in_succ_count_i     (in_succ_count),
    .in_sensor_bits_i    (in_sensor_bits),
    .in_sys_bits_i       (in_sys_bits),
    .in_region_code_i    (in_region_code),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_found_o         (out_found),
    .out_next_state_o    (out_next_state),
    .out_sys_out_o       (out_sys_out),
    .out_region_o        (out_region),
    .out_current_state_o (out_current_state)
  );

  sas_result_checker u_chk (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .in_cmd_i            (in_cmd),
    .in_state_index_i    (in_state_index),
    .in_slot_i           (in_slot),
    .in_succ_id_i        (in_succ_id),
    .in_succ_count_i     (in_succ_count),
    .in_sensor_bits_i    (in_sensor_bits),
    .in_sys_bits_i       (in_sys_bits),
    .in_region_code_i    (in_region_code),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .out_found_i         (out_found),
    .out_next_state_i    (out_next_state),
    .out_sys_out_i       (out_sys_out),
    .out_region_i        (out_region),
    .out_current_state_i (out_current_state),
    .mismatches_o        (mismatches),
    .owed_o              (owed)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver: random stall per cycle, or a long hold-off when asked for one
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // watchdog: too long without any beat moving on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // every field random, so bits the command ignores still toggle
  function automatic beat_t noisy_beat(cmd_e c);
    beat_t b;
    b.cmd         = c;
    b.state_index = STATE_W'($urandom);
    b.slot        = SLOT_W'($urandom);
    b.succ_id     = STATE_W'($urandom);
    b.succ_count  = CNT_W'($urandom);
    b.sensor_bits = SENS_W'($urandom);
    b.sys_bits    = SYS_W'($urandom);
    b.region_code = REG_W'($urandom);
    return b;
  endfunction

  function automatic beat_t entry_beat(int idx, int sens, int sys, int region, int cnt);
    beat_t b;
    b             = noisy_beat(CMD_LOAD_ENTRY);
    b.state_index = STATE_W'(idx);
    b.sensor_bits = SENS_W'(sens);
    b.sys_bits    = SYS_W'(sys);
    b.region_code = REG_W'(region);
    b.succ_count  = CNT_W'(cnt);
    return b;
  endfunction

  function automatic beat_t succ_beat(int idx, int slot, int sid);
    beat_t b;
    b             = noisy_beat(CMD_LOAD_SUCC);
    b.state_index = STATE_W'(idx);
    b.slot        = SLOT_W'(slot);
    b.succ_id     = STATE_W'(sid);
    return b;
  endfunction

  function automatic beat_t step_beat(int sens);
    beat_t b;
    b             = noisy_beat(CMD_STEP);
    b.sensor_bits = SENS_W'(sens);
    return b;
  endfunction

  function automatic logic [STATE_W-1:0] pool_state();
    if ($urandom_range(99) < 85) return pool[$urandom_range(pool.size() - 1)];
    return STATE_W'($urandom);
  endfunction

  // track what the tables hold and where the current state could have gone
  task automatic note_beat(beat_t b);
    case (b.cmd)
      CMD_LOAD_ENTRY: begin
        entry_done[b.state_index] = 1'b1;
        count_sh[b.state_index]   = (b.succ_count > 8) ? CNT_W'(8) : b.succ_count;
        sensor_sh[b.state_index]  = b.sensor_bits;
      end
      CMD_LOAD_SUCC: begin
        slot_done[b.state_index][b.slot] = 1'b1;
        succ_sh[b.state_index][b.slot]   = b.succ_id;
      end
      CMD_STEP: begin
        foreach (cur_list[i])
          for (int k = 0; k < count_sh[cur_list[i]]; k++)
            may_be_pend[succ_sh[cur_list[i]][k]] = 1'b1;
      end
      default: begin
        for (int s = 0; s < 256; s++) begin
          if (may_be_pend[s] && !may_be_cur[s]) begin
            may_be_cur[s] = 1'b1;
            cur_list.insert(cur_list.size(), s);
          end
        end
      end
    endcase
  endtask

  // find a hole that a step from any possible current state could read,
  // and return the load that fills it
  function automatic bit plan_repair(output beat_t fix);
    int r;
    logic [STATE_W-1:0] s;
    fix = noisy_beat(CMD_LOAD_ENTRY);
    foreach (cur_list[i]) begin
      r = cur_list[i];
      if (!entry_done[r]) begin
        fix = entry_beat(r, $urandom, $urandom, $urandom, 0);
        return 1'b1;
      end
      for (int k = 0; k < count_sh[r]; k++) begin
        if (!slot_done[r][k]) begin
          fix = succ_beat(r, k, r);
          return 1'b1;
        end
        s = succ_sh[r][k];
        if (!entry_done[s]) begin
          fix = entry_beat(s, $urandom, $urandom, $urandom, 0);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // steps, mostly aimed at a known successor, commits, and loads mostly in the pool
  function automatic beat_t make_random_beat();
    beat_t b;
    logic [SENS_W-1:0] smask;
    logic [STATE_W-1:0] s;
    int r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) begin
      if (plan_repair(b)) return b;
      b = noisy_beat(CMD_STEP);
      r = cur_list[$urandom_range(cur_list.size() - 1)];
      if ($urandom_range(3) != 0 && count_sh[r] != 0) begin
        // aim at one successor, scramble only the bits that are not compared
        s = succ_sh[r][$urandom_range(int'(count_sh[r]) - 1)];
        smask = (ns_set >= 16) ? '1 : SENS_W'((32'd1 << ns_set) - 1);
        b.sensor_bits = sensor_sh[s] ^ (b.sensor_bits & ~smask);
      end
    end else if (roll < 60) begin
      b = noisy_beat(CMD_COMMIT);
    end else if (roll < 80) begin
      b = noisy_beat(CMD_LOAD_ENTRY);
      b.state_index = pool_state();
      if ($urandom_range(99) < 70) b.succ_count = CNT_W'($urandom_range(1, 8));
    end else begin
      b = noisy_beat(CMD_LOAD_SUCC);
      b.state_index = pool_state();
      b.succ_id     = pool_state();
    end
    return b;
  endfunction

  // offer one beat from a falling edge and return at the falling edge after it is taken
  task automatic send_beat(beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= b.cmd;
    in_state_index <= b.state_index;
    in_slot        <= b.slot;
    in_succ_id     <= b.succ_id;
    in_succ_count  <= b.succ_count;
    in_sensor_bits <= b.sensor_bits;
    in_sys_bits    <= b.sys_bits;
    in_region_code <= b.region_code;
    note_beat(b);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop offering and wait for every owed result beat
  task automatic drain();
    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write all three registers plus one write to the unused index
  task automatic apply_setting(int ns, int np, int nst);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_NUM_SENSORS;
    cfg_wdata <= CFG_DATA_W'(ns);
    @(negedge clk);
    cfg_idx   <= CFG_NUM_SYS_PROPS;
    cfg_wdata <= CFG_DATA_W'(np);
    @(negedge clk);
    cfg_idx   <= CFG_NUM_STATES;
    cfg_wdata <= CFG_DATA_W'(nst);
    @(negedge clk);
    cfg_idx   <= CFG_NO_REG;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b0;
    ns_set     = NPROP_W'(ns);
    @(negedge clk);
  endtask

  initial begin
    int setting [N_PHASES][3];
    int first_slots [8];
    // inputs known from time zero, reset held
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_cmd         = '0;
    in_state_index = '0;
    in_slot        = '0;
    in_succ_id     = '0;
    in_succ_count  = '0;
    in_sensor_bits = '0;
    in_sys_bits    = '0;
    in_region_code = '0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    hold_req       = 1'b0;
    ns_set         = '0;
    for (int s = 0; s < 256; s++) begin
      entry_done[s]  = 1'b0;
      count_sh[s]    = '0;
      slot_done[s]   = '0;
      may_be_cur[s]  = 1'b0;
      may_be_pend[s] = 1'b0;
    end
    may_be_cur[0] = 1'b1;  // current state comes out of reset as zero
    cur_list.insert(cur_list.size(), 0);
    first_slots = '{255, 1, 0, 1, 255, 0, 1, 0};

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed, reset config: nothing compared, no props shown, every commit refused
    send_beat(noisy_beat(CMD_COMMIT));                  // commit with nothing pending
    send_beat(entry_beat(0, 'hFFFF, 'hFFFF, 'hFF, 15)); // count above eight saturates
    for (int k = 0; k < 8; k++) send_beat(succ_beat(0, k, first_slots[k]));
    send_beat(entry_beat(255, 'hA5A5, 'h5A5A, 'h80, 0));
    send_beat(entry_beat(1, 'h0000, 'h1234, 'h01, 2));
    send_beat(succ_beat(1, 0, 0));
    send_beat(succ_beat(1, 1, 255));
    send_beat(step_beat($urandom));                     // zero sensors: first slot wins
    send_beat(noisy_beat(CMD_COMMIT));                  // bound of zero refuses it
    drain();

    // directed, full widths
    apply_setting(16, 16, 256);
    send_beat(step_beat('h0000));                       // skips 255, lands on 1
    send_beat(noisy_beat(CMD_COMMIT));
    send_beat(noisy_beat(CMD_COMMIT));                  // repeated commit is harmless
    send_beat(step_beat('hFFFF));
    send_beat(step_beat('h1234));                       // no match clears the pending state
    send_beat(noisy_beat(CMD_COMMIT));
    send_beat(step_beat('hA5A5));
    send_beat(noisy_beat(CMD_COMMIT));                  // move to the top state number
    send_beat(step_beat('h5555));                       // state without successors
    send_beat(noisy_beat(CMD_COMMIT));
    drain();

    // build a well-formed automaton over a small pool of states
    pool.insert(pool.size(), STATE_W'(0));
    pool.insert(pool.size(), STATE_W'(1));
    pool.insert(pool.size(), STATE_W'(255));
    while (pool.size() < POOL_SIZE) pool.insert(pool.size(), STATE_W'($urandom));
    foreach (pool[i]) begin
      send_beat(entry_beat(pool[i], $urandom, $urandom, $urandom, $urandom_range(1, 8)));
      for (int k = 0; k < 8; k++) send_beat(succ_beat(pool[i], k, pool[$urandom_range(POOL_SIZE - 1)]));
    end
    drain();

    // settings per phase, extremes and out-of-range values among them
    setting[0] = '{0, 0, 0};
    setting[1] = '{16, 16, 256};
    setting[2] = '{$urandom_range(16), $urandom_range(16), $urandom_range(256)};
    setting[3] = '{31, 31, 511};
    setting[4] = '{1, 16, 1};
    setting[5] = '{$urandom_range(16), $urandom_range(16), $urandom_range(256)};
    setting[6] = '{16, 5, 256};
    setting[7] = '{$urandom_range(16), $urandom_range(16), $urandom_range(256)};

    for (int p = 0; p < N_PHASES; p++) begin
      // idle modes rotate: none, sender idle, receiver stalling, both
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 77; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 77; end
        default: begin tx_idle_pct = 27; rx_stall_pct <= 27; end
      endcase
      apply_setting(setting[p][0], setting[p][1], setting[p][2]);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        send_beat(make_random_beat());
        // sender keeps going while the receiver holds off, so the block backs up
        if (p == 4 && i == 10) hold_req <= ~hold_req;
      end
      drain();
    end

    repeat (40) @(negedge clk);
    if (owed != 0) $error("%0d result beats never arrived", owed);
    if (mismatches == 0 && owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/sas_pkg.sv
hw/rtl/sas_ram.sv
hw/rtl/sas_ctrl.sv
hw/rtl/sas_dp.sv
hw/rtl/strategy_automaton_stepper_top.sv
tb/sv/sas_result_checker.sv
tb/sv/testbench.sv
